@@ hdl/bcc_pkg.sv @@
package bcc_pkg;

   // status from the shared multiply/divide unit to the sequencer
   typedef struct packed {
      logic done;
      logic overflow;
   } mdu_status_type;

endpackage

@@ hdl/bcc_muldiv.sv @@
module bcc_muldiv #(
   parameter int OPERAND_BITS = 8,
   parameter int RESULT_BITS  = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [RESULT_BITS-1:0]     value,
   input  logic [OPERAND_BITS-1:0]    factor,
   input  logic [OPERAND_BITS-1:0]    divisor,
   output logic [RESULT_BITS-1:0]     quotient,
   output bcc_pkg::mdu_status_type    status
);
   import bcc_pkg::*;

   localparam int W        = RESULT_BITS + OPERAND_BITS;
   localparam int CNT_BITS = $clog2(W);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]              phase_ff, phase_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic [W-1:0]            acc_ff, acc_in;
   logic [RESULT_BITS-1:0]  value_ff, value_in;
   logic [OPERAND_BITS-1:0] factor_ff, factor_in;
   logic [OPERAND_BITS-1:0] divisor_ff, divisor_in;
   logic [OPERAND_BITS-1:0] rem_ff, rem_in;

   // the one adder, shared by the shift-add and the shift-subtract passes
   logic [W-1:0]            add_a, add_b;
   logic                    add_cin;
   logic [W:0]              add_sum;
   logic [OPERAND_BITS:0]   rem_shift;
   logic                    fits;

   assign rem_shift = {rem_ff, acc_ff[W-1]};
   assign add_sum   = {1'b0, add_a} + {1'b0, add_b} + (W+1)'(add_cin);
   // carry out of a + ~b + 1 means a >= b
   assign fits      = add_sum[W];

   always_comb begin
      if (phase_ff == PH_MUL) begin
         add_a   = {acc_ff[W-2:0], 1'b0};
         add_b   = factor_ff[OPERAND_BITS-1] ? {{OPERAND_BITS{1'b0}}, value_ff} : '0;
         add_cin = 1'b0;
      end else begin
         add_a   = {{(W-OPERAND_BITS-1){1'b0}}, rem_shift};
         add_b   = ~{{RESULT_BITS{1'b0}}, divisor_ff};
         add_cin = 1'b1;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      done_in    = 1'b0;
      acc_in     = acc_ff;
      value_in   = value_ff;
      factor_in  = factor_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in   = PH_MUL;
               cnt_in     = CNT_BITS'(OPERAND_BITS - 1);
               acc_in     = '0;
               rem_in     = '0;
               value_in   = value;
               factor_in  = factor;
               divisor_in = divisor;
            end
         end
         PH_MUL: begin
            acc_in    = add_sum[W-1:0];
            factor_in = {factor_ff[OPERAND_BITS-2:0], 1'b0};
            if (cnt_ff == '0) begin
               phase_in = PH_DIV;
               cnt_in   = CNT_BITS'(W - 1);
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         PH_DIV: begin
            acc_in = {acc_ff[W-2:0], fits};
            rem_in = fits ? add_sum[OPERAND_BITS-1:0] : rem_shift[OPERAND_BITS-1:0];
            if (cnt_ff == '0) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      acc_ff     <= acc_in;
      value_ff   <= value_in;
      factor_ff  <= factor_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
   end

   assign quotient        = acc_ff[RESULT_BITS-1:0];
   assign status.done     = done_ff;
   assign status.overflow = |acc_ff[W-1:RESULT_BITS];

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> phase_ff == PH_IDLE)
      else $error("unit started while busy");
   a_start_not_done: assert property (@(posedge clock) disable iff (reset)
      start |=> !status.done && phase_ff == PH_MUL)
      else $error("unit did not enter multiply pass");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      status.done |=> !status.done)
      else $error("done held longer than one cycle");
   a_done_after_div: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(phase_ff == PH_DIV))
      else $error("done without divide pass");
`endif

endmodule

@@ hdl/binomial_coefficient_core.sv @@
// Binomial coefficient core: returns n choose k with a saturation flag.
// Request channel: req_valid / req_stall with req_set_size (n) and
// req_choose_count (k). Response channel: rsp_valid / rsp_stall with
// rsp_coefficient and rsp_overflow. A word moves on a rising edge with
// valid high and stall low.
// The core works on one request at a time and stalls the request side
// from acceptance until the result is loaded into the response register.
// It runs r = min(k, n-k) steps, each a multiply by the next numerator
// term then an exact divide by the step index, on one shared shift-add /
// shift-subtract unit. Requests with k > n, k = 0 or k = n go straight to
// the finish state without using the unit. Steps stop at the first
// overflow, so at most 34 steps run with 64-bit results.
// A stalled response holds in its register while the next request is
// accepted and worked on; a finished result then waits for that register.
// Synchronous reset clears the sequencer and drops rsp_valid.
module binomial_coefficient_core #(
   parameter int OPERAND_BITS = 8,
   parameter int RESULT_BITS  = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OPERAND_BITS-1:0] req_set_size,
   input  logic [OPERAND_BITS-1:0] req_choose_count,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [RESULT_BITS-1:0]  rsp_coefficient,
   output logic                    rsp_overflow
);
   import bcc_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_ISSUE  = 2'd1;
   localparam logic [1:0] S_WAIT   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RESULT_BITS-1:0]  rsp_coef_ff, rsp_coef_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;
   logic [RESULT_BITS-1:0]  prod_ff, prod_in;
   logic                    ovf_ff, ovf_in;
   logic [OPERAND_BITS-1:0] step_ff, step_in;
   logic [OPERAND_BITS-1:0] last_ff, last_in;
   logic [OPERAND_BITS-1:0] base_ff, base_in;

   logic                    req_take;
   logic                    rsp_free;
   logic [OPERAND_BITS-1:0] n_minus_k;
   logic [OPERAND_BITS-1:0] steps;
   logic [OPERAND_BITS-1:0] step_next;
   logic                    unit_start;
   logic [RESULT_BITS-1:0]  unit_quot;
   mdu_status_type          unit_status;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign n_minus_k = req_set_size - req_choose_count;
   assign steps     = (req_choose_count < n_minus_k) ? req_choose_count : n_minus_k;
   assign step_next = step_ff + 1'b1;
   assign unit_start = (state_ff == S_ISSUE);

   bcc_muldiv #(
      .OPERAND_BITS (OPERAND_BITS),
      .RESULT_BITS  (RESULT_BITS)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .value    (prod_ff),
      .factor   (base_ff + step_next),
      .divisor  (step_next),
      .quotient (unit_quot),
      .status   (unit_status)
   );

   always_comb begin
      state_in     = state_ff;
      prod_in      = prod_ff;
      ovf_in       = ovf_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_coef_in  = rsp_coef_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               ovf_in  = 1'b0;
               step_in = '0;
               last_in = steps;
               base_in = req_set_size - steps;
               if (req_choose_count > req_set_size) begin
                  prod_in  = '0;
                  state_in = S_FINISH;
               end else begin
                  prod_in  = RESULT_BITS'(1);
                  state_in = (steps == '0) ? S_FINISH : S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            step_in  = step_next;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (unit_status.done) begin
               if (unit_status.overflow) begin
                  prod_in  = '1;
                  ovf_in   = 1'b1;
                  state_in = S_FINISH;
               end else begin
                  prod_in  = unit_quot;
                  state_in = (step_ff == last_ff) ? S_FINISH : S_ISSUE;
               end
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_coef_in  = prod_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      ovf_ff      <= ovf_in;
      step_ff     <= step_in;
      last_ff     <= last_in;
      base_ff     <= base_in;
      rsp_coef_ff <= rsp_coef_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = rsp_coef_ff;
   assign rsp_overflow    = rsp_ovf_ff;

`ifndef SYNTH
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("request side open right after a word was taken");
   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> &rsp_coefficient)
      else $error("overflow without saturated coefficient");
   a_load_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response loaded outside finish");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WAIT |-> step_ff != '0 && step_ff <= last_ff)
      else $error("step index out of range");
`endif

endmodule

@@ verif/bcc_checker.sv @@
`timescale 1ns / 100ps

module bcc_checker #(
   parameter int OPERAND_BITS = 8,
   parameter int RESULT_BITS  = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [OPERAND_BITS-1:0] req_set_size,
   input  logic [OPERAND_BITS-1:0] req_choose_count,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [RESULT_BITS-1:0]  rsp_coefficient,
   input  logic                    rsp_overflow,
   output int                      error_count,
   output int                      pending_words,
   output int                      checked_words,
   output int                      saturated_words
);

   typedef struct packed {
      logic [RESULT_BITS-1:0] coefficient;
      logic                   overflow;
   } choose_result_type;

   localparam int WIDE_BITS = RESULT_BITS + 2*OPERAND_BITS;

   choose_result_type expected_coefficients[$];

   // n choose k by the multiplicative form, saturating past RESULT_BITS
   function automatic choose_result_type predict_choose(input logic [OPERAND_BITS-1:0] n,
                                                        input logic [OPERAND_BITS-1:0] k);
      choose_result_type      res;
      logic [OPERAND_BITS-1:0] r;
      logic [OPERAND_BITS-1:0] base;
      logic [WIDE_BITS-1:0]   product;
      logic [WIDE_BITS-1:0]   quotient;
      logic [RESULT_BITS-1:0] running;
      int                     step;
      res.coefficient = '0;
      res.overflow    = 1'b0;
      if (k > n) return res;
      r       = (k < n - k) ? k : n - k;
      base    = n - r;
      running = RESULT_BITS'(1);
      for (step = 1; step <= int'(r); step++) begin
         product  = WIDE_BITS'(running) * (WIDE_BITS'(base) + WIDE_BITS'(step));
         // every intermediate is itself a binomial, so the divide is exact
         quotient = product / WIDE_BITS'(step);
         if (quotient[WIDE_BITS-1:RESULT_BITS] != '0) begin
            res.coefficient = '1;
            res.overflow    = 1'b1;
            return res;
         end
         running = quotient[RESULT_BITS-1:0];
      end
      res.coefficient = running;
      return res;
   endfunction

   always @(posedge clock) begin
      choose_result_type want;
      int                mismatches;
      if (reset) begin
         expected_coefficients.delete();
         error_count     <= 0;
         pending_words   <= 0;
         checked_words   <= 0;
         saturated_words <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_coefficients.push_back(predict_choose(req_set_size, req_choose_count));
         if (rsp_valid && !rsp_stall) begin
            if (expected_coefficients.size() == 0) begin
               $error("response word with nothing outstanding: coefficient %h overflow %b",
                      rsp_coefficient, rsp_overflow);
               error_count <= error_count + 1;
            end else begin
               want       = expected_coefficients.pop_front();
               mismatches = 0;
               if (rsp_coefficient !== want.coefficient) begin
                  $error("coefficient mismatch: expected %h, actual %h",
                         want.coefficient, rsp_coefficient);
                  mismatches++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow mismatch: expected %b, actual %b",
                         want.overflow, rsp_overflow);
                  mismatches++;
               end
               error_count   <= error_count + mismatches;
               checked_words <= checked_words + 1;
               if (want.overflow) saturated_words <= saturated_words + 1;
            end
         end
         pending_words <= expected_coefficients.size();
      end
   end

endmodule

@@ verif/tb_binomial_coefficient_core.sv @@
`timescale 1ns / 100ps

module tb_binomial_coefficient_core;

   localparam int OPERAND_BITS = 8;
   localparam int RESULT_BITS  = 64;
   localparam int DRAIN_CYCLES = 3000;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [OPERAND_BITS-1:0] req_set_size;
   logic [OPERAND_BITS-1:0] req_choose_count;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [RESULT_BITS-1:0]  rsp_coefficient;
   logic                    rsp_overflow;

   int error_count;
   int pending_words;
   int checked_words;
   int saturated_words;
   int sender_idle_pct;
   int receiver_stall_pct;
   int words_sent;

   binomial_coefficient_core #(
      .OPERAND_BITS(OPERAND_BITS),
      .RESULT_BITS (RESULT_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_set_size    (req_set_size),
      .req_choose_count(req_choose_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coefficient (rsp_coefficient),
      .rsp_overflow    (rsp_overflow)
   );

   bcc_checker #(
      .OPERAND_BITS(OPERAND_BITS),
      .RESULT_BITS (RESULT_BITS)
   ) choose_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_set_size    (req_set_size),
      .req_choose_count(req_choose_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coefficient (rsp_coefficient),
      .rsp_overflow    (rsp_overflow),
      .error_count     (error_count),
      .pending_words   (pending_words),
      .checked_words   (checked_words),
      .saturated_words (saturated_words)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // valid stays high from one word to the next unless an idle gap is drawn
   task automatic send_choose(input int n, input int k);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_set_size     <= OPERAND_BITS'(n);
      req_choose_count <= OPERAND_BITS'(k);
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic send_random_choose();
      int n;
      int k;
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) begin
         n = $urandom_range(255);
         k = $urandom_range(255);
      end else if (pick < 65) begin
         // region around the 64-bit saturation boundary
         n = $urandom_range(72);
         k = $urandom_range(n);
      end else if (pick < 80) begin
         n = $urandom_range(254);
         k = $urandom_range(255, n + 1);
      end else begin
         n = $urandom_range(255);
         if ($urandom_range(1)) k = $urandom_range((n < 3) ? n : 3);
         else k = n - $urandom_range((n < 3) ? n : 3);
      end
      send_choose(n, k);
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_set_size       = '0;
      req_choose_count   = '0;
      words_sent         = 0;
      sender_idle_pct    = 28;
      receiver_stall_pct = 82;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // field extremes, k above n, k of zero and of n, saturation edges
      send_choose(0, 0);
      send_choose(255, 255);
      send_choose(255, 0);
      send_choose(0, 255);
      send_choose(1, 0);
      send_choose(1, 1);
      send_choose(5, 7);
      send_choose(254, 255);
      send_choose(255, 1);
      send_choose(255, 254);
      send_choose(10, 5);
      send_choose(60, 30);
      send_choose(66, 33);
      send_choose(67, 33);
      send_choose(67, 34);
      send_choose(68, 34);
      send_choose(68, 33);
      send_choose(128, 64);
      send_choose(255, 127);
      send_choose(255, 128);
      send_choose(200, 9);
      send_choose(100, 3);
      send_choose(170, 85);

      repeat (69) send_random_choose();
      sender_idle_pct    = 82;
      receiver_stall_pct = 28;
      repeat (69) send_random_choose();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (69) send_random_choose();
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d n-choose-k requests under three handshake idling mixes",
               words_sent);
      $display("checked %0d coefficient words, %0d of them saturated",
               checked_words, saturated_words);
      if (error_count == 0 && pending_words == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d words outstanding", pending_words);
      $display("Regression FAIL");
      $finish;
   end

endmodule
